// ===== hw/rtl/brfifo_pkg.sv =====
// Shared types and constants for the byte ring FIFO with drop counter.
// No dependencies; imported by the ring memory and the top level.
package brfifo_pkg;

    localparam int REQ_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int READ_MAX_W = 7;
    localparam int LVL_W      = 9;
    localparam int DROP_W     = 32;
    localparam int CFG_W      = 4;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd8;

    // Request codes carried in the request type field.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_e;

endpackage

// ===== hw/rtl/brfifo_ram.sv =====
// Byte storage for the ring FIFO: one write port, one read port with
// registered read data. Depends on brfifo_pkg.
module brfifo_ram
    import brfifo_pkg::*;
#(
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [(1 << ADDR_W)];
    logic [BYTE_W-1:0] r_rdata;

    // Read data holds its value until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/byte_ring_fifo_with_drop_count.sv =====
// Top level of the byte ring FIFO with a counter of refused pushes.
// Depends on brfifo_pkg and brfifo_ram.
//
// Usage: requests enter on i_valid/o_ready; each carries a type (push,
// read, clear), a byte to push and the most bytes a read may deliver.
// Results leave on o_valid/i_ready, one word per pushed, refused or cleared
// request and one word per byte delivered by a read, the final word of a
// request flagged by o_last. A read that finds nothing to deliver gives a
// single word with o_ok low. Every word reports fill, free space and drops.
// A push, clear or empty read gives its word in the cycle after it is taken.
// A read of n bytes issues its first memory read when taken; its bytes pass
// the memory's read data register and the output register, one per cycle.
// Push, clear and empty reads are taken one per cycle; a read of n bytes
// blocks new requests until its last byte is loaded, the single read port
// draining in order. Both rates pause while the receiver stalls: the current
// word then holds and no new request is taken. The capacity in use is
// 2**size_log2 (saturated to the memory depth), set by i_cfg_wr_en and
// i_cfg_wr_data; the user must write it only while the block is idle, which
// the block does not enforce. Reset clears both indices, the drop counter and
// the output register and sets size_log2 to 8; the memory is not cleared.
module byte_ring_fifo_with_drop_count
    import brfifo_pkg::*;
#(
    parameter int MAX_DEPTH_LOG2 = 8,
    parameter int MAX_READ       = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [BYTE_W-1:0]     i_push_byte,
    input  logic [READ_MAX_W-1:0] i_read_max,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ok,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_last,
    output logic [LVL_W-1:0]      o_fill_count,
    output logic [LVL_W-1:0]      o_free_space,
    output logic [DROP_W-1:0]     o_drop_count
);

    // Slot address width and index width (one extra bit tells full from empty).
    localparam int AW    = MAX_DEPTH_LOG2;
    localparam int IW    = MAX_DEPTH_LOG2 + 1;
    localparam int LG_W  = $clog2(MAX_DEPTH_LOG2 + 1);

    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_state_e;

    t_state_e              r_state,     n_state;
    logic [IW-1:0]         r_wr_idx,    n_wr_idx;
    logic [IW-1:0]         r_rd_idx,    n_rd_idx;
    logic [DROP_W-1:0]     r_drops,     n_drops;
    logic [READ_MAX_W-1:0] r_remain,    n_remain;
    logic [CFG_W-1:0]      r_size_log2;
    logic                  r_out_valid, n_out_valid;
    logic                  r_ok,        n_ok;
    logic [BYTE_W-1:0]     r_byte,      n_byte;
    logic                  r_last,      n_last;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic [LG_W-1:0]       w_lg;
    logic [IW-1:0]         w_cap;
    logic [IW-1:0]         w_fill;
    logic [IW-1:0]         w_free;
    logic [READ_MAX_W-1:0] w_want;
    logic [READ_MAX_W-1:0] w_n;

    logic                  w_ram_we;
    logic                  w_ram_re;
    logic [AW-1:0]         w_ram_raddr;
    logic [BYTE_W-1:0]     w_ram_rdata;

    // The output register can take a new word when empty or being drained.
    assign w_out_free  = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE) && w_out_free;
    assign w_in_accept = i_valid && o_ready;

    // Capacity in use, with the configured log2 saturated to the memory depth.
    assign w_lg   = (int'(r_size_log2) > MAX_DEPTH_LOG2) ? LG_W'(MAX_DEPTH_LOG2)
                                                        : LG_W'(r_size_log2);
    assign w_cap  = IW'(1) << w_lg;
    assign w_fill = r_wr_idx - r_rd_idx;
    assign w_free = (w_fill >= w_cap) ? '0 : (w_cap - w_fill);

    // A read delivers the smaller of the fill and the saturated request.
    assign w_want = (int'(i_read_max) > MAX_READ) ? READ_MAX_W'(MAX_READ) : i_read_max;
    assign w_n    = (int'(w_fill) < int'(w_want)) ? READ_MAX_W'(w_fill) : w_want;

    assign w_ram_we = w_in_accept && (i_req_type == REQ_PUSH) && (w_fill < w_cap);

    brfifo_ram #(
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_idx[AW-1:0]),
        .i_wdata (i_push_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_drops     = r_drops;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !i_ready;
        n_ok        = r_ok;
        n_byte      = r_byte;
        n_last      = r_last;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_rd_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    // Every request but a non-empty read answers with one word.
                    n_out_valid = 1'b1;
                    n_ok        = 1'b0;
                    n_byte      = '0;
                    n_last      = 1'b1;
                    case (i_req_type)
                        REQ_PUSH: begin
                            if (w_fill < w_cap) begin
                                n_wr_idx = r_wr_idx + IW'(1);
                                n_ok     = 1'b1;
                            end else begin
                                n_drops = r_drops + DROP_W'(1);
                            end
                        end
                        REQ_READ: begin
                            if (w_n != '0) begin
                                // First byte is fetched now; words follow from S_DATA.
                                n_out_valid = 1'b0;
                                w_ram_re    = 1'b1;
                                n_remain    = w_n;
                                n_state     = S_DATA;
                            end
                        end
                        REQ_CLEAR: begin
                            n_wr_idx = '0;
                            n_rd_idx = '0;
                            n_drops  = '0;
                            n_ok     = 1'b1;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_byte      = w_ram_rdata;
                    n_last      = (r_remain == READ_MAX_W'(1));
                    n_rd_idx    = r_rd_idx + IW'(1);
                    n_remain    = r_remain - READ_MAX_W'(1);
                    if (r_remain == READ_MAX_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the next byte so the burst runs one word a cycle while the receiver does not stall.
                        w_ram_re    = 1'b1;
                        w_ram_raddr = n_rd_idx[AW-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_drops     <= '0;
            r_remain    <= '0;
            r_size_log2 <= SIZE_LOG2_RESET;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_byte      <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_drops     <= n_drops;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
            r_ok        <= n_ok;
            r_byte      <= n_byte;
            r_last      <= n_last;
            if (i_cfg_wr_en) begin
                r_size_log2 <= i_cfg_wr_data;
            end
        end
    end

    // The indices and drop counter only move when a new word is loaded, so
    // the levels seen beside the held word are the ones after that word.
    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_out_byte   = r_byte;
    assign o_last       = r_last;
    assign o_fill_count = LVL_W'(w_fill);
    assign o_free_space = LVL_W'(w_free);
    assign o_drop_count = r_drops;

`ifndef ASSERT_OFF
    // A burst in progress always has at least one byte left to deliver.
    a_burst_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_remain != '0))
        else $error("read burst active with no bytes remaining");

    // The ring never holds more bytes than it has slots.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(w_fill) <= (1 << AW)))
        else $error("fill exceeds ring depth");

    // A word without the last flag can only come from an unfinished burst.
    a_not_last_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == S_DATA))
        else $error("non-final word outside a read burst");

    // Nothing is written to the ring while a burst drains it.
    a_no_write_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |=> (r_wr_idx == $past(r_wr_idx)))
        else $error("write index moved during a read burst");
`endif

endmodule
